/* hw/rtl/khz_pkg.sv */
// Khazad cipher package: operation codes, controller-to-datapath command struct,
// the S-box, the H matrix row and the round functions shared by the datapath.
// No dependencies.
package khz_pkg;

   // Datapath operation codes
   typedef enum logic [2:0] {
      OP_IDLE      = 3'd0,
      OP_KEY       = 3'd1,
      OP_ENC_FIRST = 3'd2,
      OP_ENC_ROUND = 3'd3,
      OP_ENC_LAST  = 3'd4,
      OP_DEC_FIRST = 3'd5,
      OP_DEC_ROUND = 3'd6,
      OP_DEC_LAST  = 3'd7
   } op_type;

   // Command from the controller to the datapath
   typedef struct packed {
      op_type op;
      logic   out_load;
   } cmd_type;

   // Request type codes
   localparam logic REQ_ENCRYPT = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   localparam logic [7:0] SBOX [256] = '{
      8'hBA,8'h54,8'h2F,8'h74,8'h53,8'hD3,8'hD2,8'h4D,8'h50,8'hAC,8'h8D,8'hBF,8'h70,8'h52,8'h9A,8'h4C,
      8'hEA,8'hD5,8'h97,8'hD1,8'h33,8'h51,8'h5B,8'hA6,8'hDE,8'h48,8'hA8,8'h99,8'hDB,8'h32,8'hB7,8'hFC,
      8'hE3,8'h9E,8'h91,8'h9B,8'hE2,8'hBB,8'h41,8'h6E,8'hA5,8'hCB,8'h6B,8'h95,8'hA1,8'hF3,8'hB1,8'h02,
      8'hCC,8'hC4,8'h1D,8'h14,8'hC3,8'h63,8'hDA,8'h5D,8'h5F,8'hDC,8'h7D,8'hCD,8'h7F,8'h5A,8'h6C,8'h5C,
      8'hF7,8'h26,8'hFF,8'hED,8'hE8,8'h9D,8'h6F,8'h8E,8'h19,8'hA0,8'hF0,8'h89,8'h0F,8'h07,8'hAF,8'hFB,
      8'h08,8'h15,8'h0D,8'h04,8'h01,8'h64,8'hDF,8'h76,8'h79,8'hDD,8'h3D,8'h16,8'h3F,8'h37,8'h6D,8'h38,
      8'hB9,8'h73,8'hE9,8'h35,8'h55,8'h71,8'h7B,8'h8C,8'h72,8'h88,8'hF6,8'h2A,8'h3E,8'h5E,8'h27,8'h46,
      8'h0C,8'h65,8'h68,8'h61,8'h03,8'hC1,8'h57,8'hD6,8'hD9,8'h58,8'hD8,8'h66,8'hD7,8'h3A,8'hC8,8'h3C,
      8'hFA,8'h96,8'hA7,8'h98,8'hEC,8'hB8,8'hC7,8'hAE,8'h69,8'h4B,8'hAB,8'hA9,8'h67,8'h0A,8'h47,8'hF2,
      8'hB5,8'h22,8'hE5,8'hEE,8'hBE,8'h2B,8'h81,8'h12,8'h83,8'h1B,8'h0E,8'h23,8'hF5,8'h45,8'h21,8'hCE,
      8'h49,8'h2C,8'hF9,8'hE6,8'hB6,8'h28,8'h17,8'h82,8'h1A,8'h8B,8'hFE,8'h8A,8'h09,8'hC9,8'h87,8'h4E,
      8'hE1,8'h2E,8'hE4,8'hE0,8'hEB,8'h90,8'hA4,8'h1E,8'h85,8'h60,8'h00,8'h25,8'hF4,8'hF1,8'h94,8'h0B,
      8'hE7,8'h75,8'hEF,8'h34,8'h31,8'hD4,8'hD0,8'h86,8'h7E,8'hAD,8'hFD,8'h29,8'h30,8'h3B,8'h9F,8'hF8,
      8'hC6,8'h13,8'h06,8'h05,8'hC5,8'h11,8'h77,8'h7C,8'h7A,8'h78,8'h36,8'h1C,8'h39,8'h59,8'h18,8'h56,
      8'hB3,8'hB0,8'h24,8'h20,8'hB2,8'h92,8'hA3,8'hC0,8'h44,8'h62,8'h10,8'hB4,8'h84,8'h43,8'h93,8'hC2,
      8'h4A,8'hBD,8'h8F,8'h2D,8'hBC,8'h9C,8'h6A,8'h40,8'hCF,8'hA2,8'h80,8'h4F,8'h1F,8'hCA,8'hAA,8'h42
   };

   // First row of the involutional matrix H
   localparam logic [7:0] HROW [8] = '{8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08, 8'h0B, 8'h07};

   // Multiply by x in GF(2^8) modulo 0x11D
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1D : 8'h00);
   endfunction

   // Multiply by a small constant (at most four bits wide)
   function automatic logic [7:0] gf_mul_const(input logic [7:0] a, input logic [7:0] c);
      logic [7:0] x;
      logic [7:0] r;
      x = a;
      r = 8'h00;
      for (int i = 0; i < 4; i++) begin
         if (c[i]) begin
            r = r ^ x;
         end
         x = xtime(x);
      end
      return r;
   endfunction

   // Byte-wise S-box layer
   function automatic logic [63:0] sub_layer(input logic [63:0] w);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[63-8*i -: 8] = SBOX[w[63-8*i -: 8]];
      end
      return r;
   endfunction

   // Diffusion layer: multiply the byte row by H
   function automatic logic [63:0] mix_layer(input logic [63:0] w);
      logic [63:0] r;
      logic [7:0]  acc;
      for (int j = 0; j < 8; j++) begin
         acc = 8'h00;
         for (int i = 0; i < 8; i++) begin
            acc = acc ^ gf_mul_const(w[63-8*i -: 8], HROW[3'(i ^ j)]);
         end
         r[63-8*j -: 8] = acc;
      end
      return r;
   endfunction

   // Round constant: eight consecutive S-box entries starting at 8r
   function automatic logic [63:0] round_const(input logic [4:0] r);
      logic [63:0] c;
      for (int j = 0; j < 8; j++) begin
         c[63-8*j -: 8] = SBOX[{r, 3'(j)}];
      end
      return c;
   endfunction

endpackage

/* hw/rtl/khz_datapath.sv */
// Khazad datapath: key registers, round key store, key schedule step and the
// shared round unit with the block state and result registers. Uses khz_pkg.
module khz_datapath #(
   parameter int ROUNDS = 8,
   localparam int KIW = $clog2(ROUNDS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  khz_pkg::cmd_type  cmd,
   input  logic [KIW-1:0]    key_idx,
   input  logic              key_high_we,
   input  logic              key_low_we,
   input  logic [63:0]       cfg_data,
   input  logic [63:0]       req_block_in,
   output logic [63:0]       rsp_block_out,
   output logic [63:0]       key_high,
   output logic [63:0]       key_low
);
   import khz_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   logic [63:0] rk_ff [ROUNDS+1];
   logic [63:0] km1_ff, km2_ff;
   logic [63:0] x_ff, x_in;
   logic [63:0] out_ff, out_in;
   logic [63:0] rk;
   logic [63:0] km1_src, km2_src, k_next;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         if (key_high_we) begin
            key_high_ff <= cfg_data;
         end
         if (key_low_we) begin
            key_low_ff <= cfg_data;
         end
      end
   end

   // Key schedule step: the first step starts from the key registers
   assign km1_src = (key_idx == '0) ? key_low_ff  : km1_ff;
   assign km2_src = (key_idx == '0) ? key_high_ff : km2_ff;
   assign k_next  = mix_layer(sub_layer(km1_src)) ^ round_const(5'(key_idx)) ^ km2_src;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_KEY) begin
         rk_ff[key_idx] <= k_next;
         km2_ff         <= km1_src;
         km1_ff         <= k_next;
      end
   end

   assign rk = rk_ff[key_idx];

   // Shared round unit
   always_comb begin
      x_in   = x_ff;
      out_in = out_ff;
      case (cmd.op)
         OP_ENC_FIRST: x_in   = req_block_in ^ rk;
         OP_ENC_ROUND: x_in   = mix_layer(sub_layer(x_ff)) ^ rk;
         OP_ENC_LAST:  out_in = sub_layer(x_ff) ^ rk;
         OP_DEC_FIRST: x_in   = sub_layer(req_block_in ^ rk);
         OP_DEC_ROUND: x_in   = sub_layer(mix_layer(x_ff ^ rk));
         OP_DEC_LAST:  out_in = x_ff ^ rk;
         default: begin
            x_in   = x_ff;
            out_in = out_ff;
         end
      endcase
   end

   // Block state and result registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_block_out = out_ff;
   assign key_high      = key_high_ff;
   assign key_low       = key_low_ff;

endmodule

/* hw/rtl/khz_ctrl.sv */
// Khazad controller: key schedule sequencing, round counting and the result
// valid flag. Drives the datapath through khz_pkg::cmd_type. Uses khz_pkg.
module khz_ctrl #(
   parameter int ROUNDS = 8,
   localparam int KIW = $clog2(ROUNDS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_type,
   input  logic              rsp_stall,
   input  logic              cfg_wr,
   output logic              req_stall,
   output logic              rsp_valid,
   output khz_pkg::cmd_type  cmd,
   output logic [KIW-1:0]    key_idx
);
   import khz_pkg::*;

   typedef enum logic [2:0] {
      ST_KEYGEN = 3'b001,
      ST_IDLE   = 3'b010,
      ST_RUN    = 3'b100
   } state_type;

   localparam logic [KIW-1:0] LAST_IDX = KIW'(ROUNDS);

   state_type      state_ff, state_in;
   logic [KIW-1:0] cnt_ff, cnt_in;
   logic           dir_ff, dir_in;
   logic           out_valid_ff, out_valid_in;
   logic           out_free;
   logic           req_take;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign req_take = (state_ff == ST_IDLE) && req_valid && !cfg_wr;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dir_in   = dir_ff;
      cmd.op       = OP_IDLE;
      cmd.out_load = 1'b0;
      key_idx  = cnt_ff;
      case (state_ff)
         ST_KEYGEN: begin
            cmd.op = OP_KEY;
            cnt_in = cnt_ff + KIW'(1);
            if (cnt_ff == LAST_IDX) begin
               // schedule complete: park the counter at the first round key
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               dir_in   = req_type;
               cnt_in   = KIW'(1);
               state_in = ST_RUN;
               if (req_type == REQ_DECRYPT) begin
                  cmd.op  = OP_DEC_FIRST;
                  key_idx = LAST_IDX;
               end else begin
                  cmd.op  = OP_ENC_FIRST;
                  key_idx = '0;
               end
            end
         end
         ST_RUN: begin
            key_idx = (dir_ff == REQ_DECRYPT) ? (LAST_IDX - cnt_ff) : cnt_ff;
            if (cnt_ff != LAST_IDX) begin
               cmd.op = (dir_ff == REQ_DECRYPT) ? OP_DEC_ROUND : OP_ENC_ROUND;
               cnt_in = cnt_ff + KIW'(1);
            end else if (out_free) begin
               // hold the last round until the result register is free
               cmd.op       = (dir_ff == REQ_DECRYPT) ? OP_DEC_LAST : OP_ENC_LAST;
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_KEYGEN;
            cnt_in   = '0;
         end
      endcase
      // a key write restarts the schedule
      if (cfg_wr) begin
         state_in = ST_KEYGEN;
         cnt_in   = '0;
      end
   end

   // Result valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KEYGEN;
         cnt_ff       <= '0;
         dir_ff       <= REQ_ENCRYPT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dir_ff       <= dir_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || cfg_wr;
   assign rsp_valid = out_valid_ff;

   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten while pending");

   // A key write always restarts the schedule from the first round key
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (state_ff == ST_KEYGEN) && (cnt_ff == '0))
      else $error("key write did not restart the schedule");

   // An accepted item starts its rounds with the round counter at one
   a_req_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RUN) && (cnt_ff == KIW'(1)))
      else $error("accepted item did not start its rounds");

   // A finished item waits in the last round while the result is blocked
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && (cnt_ff == LAST_IDX) && !out_free && !cfg_wr
      |=> (state_ff == ST_RUN) && (cnt_ff == LAST_IDX))
      else $error("last round left while result was blocked");

   // The counter never runs past the last round key
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_KEYGEN) |-> (cnt_ff <= LAST_IDX))
      else $error("round counter out of range");

endmodule

/* hw/rtl/khazad_block_cipher.sv */
// Khazad block cipher top level: APB-style key port, request and response
// channels, controller and datapath. Uses khz_pkg, khz_ctrl and khz_datapath.
//
// Usage:
//  - Key: write key_high at byte address 0 and key_low at byte address 8
//    (64-bit data). Each write derives the ROUNDS+1 round keys, during which
//    req_stall is high. Reads return the key registers.
//  - Request: req_type (0 encrypt, 1 decrypt) and req_block_in are taken when
//    req_valid is high and req_stall is low.
//  - Response: rsp_block_out is offered with rsp_valid and held while
//    rsp_stall is high.
//  - Timing: each item runs in the single shared round unit: the accept cycle
//    adds the first key, then one round per cycle unless the last round is held
//    for the result register. The result is valid in the cycle after the last
//    round, and the next item is taken in that same cycle; no new item is taken
//    while one is still in its rounds.
//  - Reset: keys return to zero and the all-zero-key schedule is derived before
//    the first item is taken.
//  - Stall: while a result waits, the next item still runs its rounds and then
//    holds in its last round until the result register frees.
module khazad_block_cipher #(
   parameter int ROUNDS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] req_block_in,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_block_out,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import khz_pkg::*;

   localparam int KIW = $clog2(ROUNDS + 1);
   localparam logic REG_KEY_HIGH = 1'b0;
   localparam logic REG_KEY_LOW  = 1'b1;

   cmd_type        cmd;
   logic [KIW-1:0] key_idx;
   logic           cfg_wr;
   logic [63:0]    key_high, key_low;

   // Register access: index is the 8-byte word
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_KEY_LOW) ? key_low : key_high;

   khz_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .rsp_stall (rsp_stall),
      .cfg_wr    (cfg_wr),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .key_idx   (key_idx)
   );

   khz_datapath #(.ROUNDS(ROUNDS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .key_idx       (key_idx),
      .key_high_we   (cfg_wr && (csr_paddr[3] == REG_KEY_HIGH)),
      .key_low_we    (cfg_wr && (csr_paddr[3] == REG_KEY_LOW)),
      .cfg_data      (csr_pwdata),
      .req_block_in  (req_block_in),
      .rsp_block_out (rsp_block_out),
      .key_high      (key_high),
      .key_low       (key_low)
   );

endmodule

/* dv/khazad_block_cipher_tb.sv */
// Testbench for khazad_block_cipher: encrypt and decrypt items against a local Khazad
// predictor, with key writes and readbacks over the APB-style key port in between.
// Depends on khz_pkg (request codes) and the khazad_block_cipher RTL.
module khazad_block_cipher_tb;

   localparam int ROUNDS      = 8;
   localparam int CLK_PERIOD  = 10;
   localparam int RESET_LEN   = 6;
   localparam int QUIET_LIMIT = 4000;
   localparam int SEG_ITEMS   = 45;
   localparam int TAIL_CYCLES = 2 * (ROUNDS + 1);

   // sender idle and receiver stall, in percent, for each phase of the run
   localparam int SEND_IDLE [3] = '{16, 83, 0};
   localparam int RECV_STALL [3] = '{83, 16, 0};

   // key registers, at byte address 8*index
   typedef enum logic [0:0] {
      KEY_HIGH = 1'b0,
      KEY_LOW  = 1'b1
   } key_reg_type;

   typedef struct packed {
      logic        dec;
      logic [63:0] blk;
   } vector_type;

   // S-box, one row of sixteen entries per word, entry 0 most significant
   localparam logic [2047:0] SBOX_BITS = {
      128'hBA542F7453D3D24D50AC8DBF70529A4C,
      128'hEAD597D133515BA6DE48A899DB32B7FC,
      128'hE39E919BE2BB416EA5CB6B95A1F3B102,
      128'hCCC41D14C363DA5D5FDC7DCD7F5A6C5C,
      128'hF726FFEDE89D6F8E19A0F0890F07AFFB,
      128'h08150D040164DF7679DD3D163F376D38,
      128'hB973E93555717B8C7288F62A3E5E2746,
      128'h0C65686103C157D6D958D866D73AC83C,
      128'hFA96A798ECB8C7AE694BABA9670A47F2,
      128'hB522E5EEBE2B8112831B0E23F54521CE,
      128'h492CF9E6B62817821A8BFE8A09C9874E,
      128'hE12EE4E0EB90A41E85600025F4F1940B,
      128'hE775EF3431D4D0867EADFD29303B9FF8,
      128'hC6130605C511777C7A78361C39591856,
      128'hB3B02420B292A3C0446210B4844393C2,
      128'h4ABD8F2DBC9C6A40CFA2804F1FCAAA42
   };

   // first row of the involutional diffusion matrix
   localparam logic [63:0] H_ROW = 64'h01_03_04_05_06_08_0B_07;

   // directed items: extremes and patterns, both directions
   localparam vector_type DIRECTED [8] = '{
      '{khz_pkg::REQ_ENCRYPT, 64'h0000_0000_0000_0000},
      '{khz_pkg::REQ_DECRYPT, 64'h0000_0000_0000_0000},
      '{khz_pkg::REQ_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF},
      '{khz_pkg::REQ_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF},
      '{khz_pkg::REQ_ENCRYPT, 64'h8000_0000_0000_0000},
      '{khz_pkg::REQ_DECRYPT, 64'h0000_0000_0000_0001},
      '{khz_pkg::REQ_ENCRYPT, 64'h0123_4567_89AB_CDEF},
      '{khz_pkg::REQ_DECRYPT, 64'hAA55_AA55_AA55_AA55}
   };

   // key settings for the directed passes: reset key, all ones, split
   localparam logic [63:0] DIR_KEY_HI [3] = '{64'h0, {64{1'b1}}, 64'h0};
   localparam logic [63:0] DIR_KEY_LO [3] = '{64'h0, {64{1'b1}}, {64{1'b1}}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [63:0] req_block_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_block_out;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [63:0] cipher_key_hi = '0;
   logic [63:0] cipher_key_lo = '0;
   logic [63:0] sched_keys [0:ROUNDS];
   logic [63:0] pending_blocks [$];

   int send_idle_pct = SEND_IDLE[0];
   int recv_stall_pct = RECV_STALL[0];
   int mismatches = 0;
   int quiet_cycles = 0;

   khazad_block_cipher #(
      .ROUNDS(ROUNDS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_block_in (req_block_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_block_out(rsp_block_out),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] sbox_of(input logic [7:0] v);
      return SBOX_BITS[2047 - 8 * int'(v) -: 8];
   endfunction

   // multiply in GF(2^8), reducing by x^8+x^4+x^3+x^2+1
   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      x = {1'b0, a};
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc ^= x[7:0];
         end
         x = x << 1;
         if (x[8]) begin
            x ^= 9'h11D;
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] subst_bytes(input logic [63:0] w);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = sbox_of(w[8*i +: 8]);
      end
      return r;
   endfunction

   // byte row times H, where H[i][j] = H_ROW[i xor j]
   function automatic logic [63:0] diffuse(input logic [63:0] w);
      logic [63:0] r;
      logic [7:0]  acc;
      for (int j = 0; j < 8; j++) begin
         acc = '0;
         for (int i = 0; i < 8; i++) begin
            acc ^= gf_times(w[63 - 8*i -: 8], H_ROW[63 - 8*(i ^ j) -: 8]);
         end
         r[63 - 8*j -: 8] = acc;
      end
      return r;
   endfunction

   function automatic logic [63:0] round_constant(input int r);
      logic [63:0] c;
      for (int j = 0; j < 8; j++) begin
         c[63 - 8*j -: 8] = sbox_of(8'(8 * r + j));
      end
      return c;
   endfunction

   // expand the held key into the ROUNDS+1 round keys
   function automatic void rebuild_schedule();
      logic [63:0] prev2;
      logic [63:0] prev1;
      logic [63:0] k;
      prev2 = cipher_key_hi;
      prev1 = cipher_key_lo;
      for (int r = 0; r <= ROUNDS; r++) begin
         k = diffuse(subst_bytes(prev1)) ^ round_constant(r) ^ prev2;
         sched_keys[r] = k;
         prev2 = prev1;
         prev1 = k;
      end
   endfunction

   function automatic logic [63:0] cipher_block(input logic dec, input logic [63:0] blk);
      logic [63:0] x;
      x = blk;
      if (dec == khz_pkg::REQ_ENCRYPT) begin
         x ^= sched_keys[0];
         for (int r = 1; r < ROUNDS; r++) begin
            x = diffuse(subst_bytes(x)) ^ sched_keys[r];
         end
         x = subst_bytes(x) ^ sched_keys[ROUNDS];
      end else begin
         x = subst_bytes(x ^ sched_keys[ROUNDS]);
         for (int r = ROUNDS - 1; r >= 1; r--) begin
            x = subst_bytes(diffuse(x ^ sched_keys[r]));
         end
         x ^= sched_keys[0];
      end
      return x;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   // predict on accepted items, compare accepted results, watch for a hang
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_blocks.push_back(cipher_block(req_type, req_block_in));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_blocks.size() == 0) begin
               flag_mismatch("unexpected result", rsp_block_out, 'x);
            end else begin
               want = pending_blocks.pop_front();
               if (rsp_block_out !== want) begin
                  flag_mismatch("block_out", rsp_block_out, want);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("FAIL khazad_block_cipher");
            $finish;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // ---------------------------------------------------------------- stimulus

   // offer one item after a random idle stretch; return at the accepting edge
   task automatic send_block(input logic dec, input logic [63:0] blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= dec;
      req_block_in <= blk;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and hold until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_blocks.size() != 0);
   endtask

   task automatic write_key(input key_reg_type which, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // register taken at this edge: track it and re-expand
      if (which == KEY_HIGH) begin
         cipher_key_hi = value;
      end else begin
         cipher_key_lo = value;
      end
      rebuild_schedule();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_key_readback(input key_reg_type which);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {which, 3'b000};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== ((which == KEY_HIGH) ? cipher_key_hi : cipher_key_lo)) begin
         flag_mismatch(which == KEY_HIGH ? "key_high readback" : "key_low readback",
                       csr_prdata, (which == KEY_HIGH) ? cipher_key_hi : cipher_key_lo);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // random blocks, with extremes, single set bits and single cleared bits mixed in
   function automatic logic [63:0] random_block();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(63);
         3: return ~(64'h1 << $urandom_range(63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      rebuild_schedule();
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      // directed pass under the reset key, then under extreme keys
      for (int k = 0; k < 3; k++) begin
         if (k > 0) begin
            write_key(KEY_HIGH, DIR_KEY_HI[k]);
            write_key(KEY_LOW, DIR_KEY_LO[k]);
         end
         check_key_readback(KEY_HIGH);
         check_key_readback(KEY_LOW);
         foreach (DIRECTED[i]) begin
            send_block(DIRECTED[i].dec, DIRECTED[i].blk);
         end
         drain_results();
      end

      // random items over three idle plans, rekeying between segments
      for (int p = 0; p < 3; p++) begin
         send_idle_pct  = SEND_IDLE[p];
         recv_stall_pct = RECV_STALL[p];
         for (int seg = 0; seg < 3; seg++) begin
            if (seg != 2) begin
               write_key(KEY_HIGH, {$urandom, $urandom});
            end
            if (seg != 1) begin
               write_key(KEY_LOW, {$urandom, $urandom});
            end
            check_key_readback(KEY_HIGH);
            check_key_readback(KEY_LOW);
            repeat (SEG_ITEMS) begin
               send_block(1'($urandom_range(1)), random_block());
            end
            drain_results();
         end
      end

      // allow a stray late result to show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS khazad_block_cipher");
      end else begin
         $display("FAIL khazad_block_cipher");
      end
      $finish;
   end

endmodule

/* khazad_block_cipher.f */
hw/rtl/khz_pkg.sv
hw/rtl/khz_datapath.sv
hw/rtl/khz_ctrl.sv
hw/rtl/khazad_block_cipher.sv
dv/khazad_block_cipher_tb.sv
